/* src/hdlc_byte_unstuff_deframer_assert.svh */
// Assertion macros for the deframer's top-level RTL file.
`ifndef HDLC_BYTE_UNSTUFF_DEFRAMER_ASSERT_SVH
`define HDLC_BYTE_UNSTUFF_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBUD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbud same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HBUD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbud next-cycle check failed");

`endif

/* src/hbud_pkg.sv */
// Types and constants shared by the deframer modules.
package hbud_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   localparam int LEN_W = 17;
   localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 17'h10000;

   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef enum logic {
      KIND_DATA  = 1'b0,
      KIND_CLOSE = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data_byte;
   } cmd_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic in_frame;
      logic escape_seen;
   } front_status_type;

   typedef struct packed {
      logic             held_valid;
      logic [LEN_W-1:0] frame_count;
   } back_status_type;

   localparam int CMD_W = $bits(cmd_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

endpackage

/* src/hbud_fifo.sv */
// Small flop-based queue with a single read port.
module hbud_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/hbud_front.sv */
// Front end: flag hunt, escape removal and byte classification.
module hbud_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  rx_byte,
   output logic                        cmd_push,
   output hbud_pkg::cmd_item_type      cmd_item,
   output hbud_pkg::front_status_type  status
);

   logic in_frame_ff, in_frame_in;
   logic escape_ff, escape_in;

   always_comb begin
      in_frame_in        = in_frame_ff;
      escape_in          = escape_ff;
      cmd_push           = 1'b0;
      cmd_item.kind      = hbud_pkg::KIND_DATA;
      cmd_item.data_byte = escape_ff ? (rx_byte ^ hbud_pkg::ESC_XOR) : rx_byte;
      if (accept) begin
         if (!in_frame_ff) begin
            // hunt: drop everything up to the first flag
            if (rx_byte == hbud_pkg::FLAG_BYTE) begin
               in_frame_in = 1'b1;
               escape_in   = 1'b0;
            end
         end else if (rx_byte == hbud_pkg::FLAG_BYTE) begin
            cmd_push      = 1'b1;
            cmd_item.kind = hbud_pkg::KIND_CLOSE;
            escape_in     = 1'b0;
         end else if (rx_byte == hbud_pkg::ESC_BYTE) begin
            escape_in = 1'b1;
         end else begin
            cmd_push  = 1'b1;
            escape_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
      end
   end

   assign status.in_frame    = in_frame_ff;
   assign status.escape_seen = escape_ff;

endmodule

/* src/hbud_back.sv */
// Back end: length limit, one-byte hold-back and last marking.
module hbud_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hbud_pkg::LEN_W-1:0]          max_frame_bytes,
   input  logic                                cmd_valid,
   input  hbud_pkg::cmd_item_type              cmd_item,
   output logic                                cmd_pop,
   input  logic                                rsp_full,
   output logic                                rsp_push,
   output hbud_pkg::rsp_item_type              rsp_item,
   output hbud_pkg::back_status_type           status
);

   logic [hbud_pkg::LEN_W-1:0] count_ff, count_in;
   logic                       held_valid_ff, held_valid_in;
   logic [7:0]                 held_byte_ff, held_byte_in;

   assign cmd_pop = cmd_valid && !rsp_full;

   always_comb begin
      count_in           = count_ff;
      held_valid_in      = held_valid_ff;
      held_byte_in       = held_byte_ff;
      rsp_push           = 1'b0;
      rsp_item.data_byte = held_byte_ff;
      rsp_item.last      = 1'b0;
      if (cmd_pop) begin
         case (cmd_item.kind)
            hbud_pkg::KIND_CLOSE: begin
               // release the held byte as the frame's final byte
               rsp_push      = held_valid_ff;
               rsp_item.last = 1'b1;
               held_valid_in = 1'b0;
               count_in      = '0;
            end
            hbud_pkg::KIND_DATA: begin
               if (count_ff < max_frame_bytes) begin
                  count_in      = count_ff + hbud_pkg::LEN_W'(1);
                  rsp_push      = held_valid_ff;
                  held_byte_in  = cmd_item.data_byte;
                  held_valid_in = 1'b1;
               end
            end
            default: begin
               held_valid_in = held_valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   assign status.held_valid  = held_valid_ff;
   assign status.frame_count = count_ff;

endmodule

/* src/hdlc_byte_unstuff_deframer.sv */
// Top level of the HDLC byte-unstuffing receive deframer.
//
// Usage:
//   Input channel: drive req_rx_byte and raise req_push; a line byte is taken
//   at each clock edge with req_push high and req_full low.
//   Result channel: while rsp_empty is low, rsp_data_byte / rsp_last show the
//   oldest waiting payload byte; raise rsp_pop to take it.
//   CSR: pulse csr_wr_en with csr_wr_data to set the per-frame byte limit
//   (reset value 65536); write it only while the block is idle.
// Timing:
//   One line byte per clock, sustained while req_full is low. The front end
//   classifies a byte in the cycle it is taken and queues it; the back end
//   executes one queued transaction per clock unless the result queue is full.
//   A payload byte is held back until the byte that releases it (the next payload
//   byte or the closing flag) leaves the command queue; then it enters the result queue.
// Reset: synchronous, active high; the block hunts for a flag again and both
//   queues empty. No clearing pass is needed.
// Stall: when rsp_pop stays low the result queue fills, the back end stops,
//   the command queue fills behind it and req_full then rises.
module hdlc_byte_unstuff_deframer #(
   parameter int CMD_DEPTH = hbud_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = hbud_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [7:0]                 rsp_data_byte,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [hbud_pkg::LEN_W-1:0] csr_wr_data
);

`include "hdlc_byte_unstuff_deframer_assert.svh"

   logic [hbud_pkg::LEN_W-1:0] max_frame_ff, max_frame_in;

   logic                       req_accept;
   logic                       cmd_push, cmd_full, cmd_empty, cmd_pop;
   hbud_pkg::cmd_item_type     cmd_wr_item, cmd_rd_item;
   logic                       rsp_push, rsp_full;
   hbud_pkg::rsp_item_type     rsp_wr_item, rsp_rd_item;
   hbud_pkg::front_status_type front_status;
   hbud_pkg::back_status_type  back_status;

   // hold the frame length limit; update on every CSR write
   assign max_frame_in = csr_wr_en ? csr_wr_data : max_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= hbud_pkg::MAX_FRAME_RESET;
      end else begin
         max_frame_ff <= max_frame_in;
      end
   end

   // back-pressure comes only from the command queue
   assign req_full   = cmd_full;
   assign req_accept = req_push && !cmd_full;

   hbud_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .rx_byte  (req_rx_byte),
      .cmd_push (cmd_push),
      .cmd_item (cmd_wr_item),
      .status   (front_status)
   );

   hbud_fifo #(
      .WIDTH (hbud_pkg::CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_item),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_item),
      .empty     (cmd_empty)
   );

   hbud_back u_back (
      .clock           (clock),
      .reset           (reset),
      .max_frame_bytes (max_frame_ff),
      .cmd_valid       (!cmd_empty),
      .cmd_item        (cmd_rd_item),
      .cmd_pop         (cmd_pop),
      .rsp_full        (rsp_full),
      .rsp_push        (rsp_push),
      .rsp_item        (rsp_wr_item),
      .status          (back_status)
   );

   // result queue: lets input keep flowing while a result waits
   hbud_fifo #(
      .WIDTH (hbud_pkg::RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd_item),
      .empty     (rsp_empty)
   );

   assign rsp_data_byte = rsp_rd_item.data_byte;
   assign rsp_last      = rsp_rd_item.last;

   // A closing byte always empties the hold register.
   `HBUD_ASSERT_NEXT(a_close_clears_hold, clock, reset, rsp_push && rsp_wr_item.last, !back_status.held_valid)
   // A non-final byte leaves its successor in the hold register.
   `HBUD_ASSERT_NEXT(a_mid_keeps_hold, clock, reset, rsp_push && !rsp_wr_item.last, back_status.held_valid)
   // While hunting for the first flag, nothing is queued on either side.
   `HBUD_ASSERT_IMPLY(a_hunt_idle, clock, reset, !front_status.in_frame, cmd_empty && rsp_empty && !back_status.held_valid)
   // The back end never pushes into a full result queue.
   `HBUD_ASSERT_IMPLY(a_no_overflow, clock, reset, rsp_push, !rsp_full)

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the HDLC byte-unstuffing receive deframer.
`timescale 1ns / 1ps

module tb_top;
   import hbud_pkg::*;

   // Directed table: a row either types in its own expected result or leaves
   // the result to the unstuffing predictor.
   localparam bit TYPED = 1'b1;
   localparam bit PRED  = 1'b0;
   localparam bit RES   = 1'b1;
   localparam bit NONE  = 1'b0;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       typed;
      logic       has_result;
      logic [7:0] data_byte;
      logic       last;
   } line_row_type;

   localparam int N_ROWS = 23;
   localparam line_row_type LINE_ROWS [N_ROWS] = '{
      // hunting: drop everything until the first flag
      '{8'h00,     TYPED, NONE, 8'h00, 1'b0},
      '{8'hFF,     TYPED, NONE, 8'h00, 1'b0},
      '{ESC_BYTE,  TYPED, NONE, 8'h00, 1'b0},
      '{FLAG_BYTE, TYPED, NONE, 8'h00, 1'b0},
      // two adjacent flags: empty frame
      '{FLAG_BYTE, TYPED, NONE, 8'h00, 1'b0},
      // extremes of the payload byte, released one step late
      '{8'h00,     TYPED, NONE, 8'h00, 1'b0},
      '{8'hFF,     TYPED, RES,  8'h00, 1'b0},
      '{FLAG_BYTE, TYPED, RES,  8'hFF, 1'b1},
      // escaped flag and escaped escape
      '{ESC_BYTE,  TYPED, NONE, 8'h00, 1'b0},
      '{8'h5E,     TYPED, NONE, 8'h00, 1'b0},
      '{ESC_BYTE,  PRED,  NONE, 8'h00, 1'b0},
      '{8'h5D,     PRED,  NONE, 8'h00, 1'b0},
      // escape then escape: the second one only keeps the escape pending
      '{ESC_BYTE,  PRED,  NONE, 8'h00, 1'b0},
      '{ESC_BYTE,  PRED,  NONE, 8'h00, 1'b0},
      '{8'h5E,     PRED,  NONE, 8'h00, 1'b0},
      // escape then flag: the flag closes, the escape is forgotten
      '{ESC_BYTE,  PRED,  NONE, 8'h00, 1'b0},
      '{FLAG_BYTE, PRED,  NONE, 8'h00, 1'b0},
      // frame of escapes only: no result
      '{ESC_BYTE,  TYPED, NONE, 8'h00, 1'b0},
      '{FLAG_BYTE, TYPED, NONE, 8'h00, 1'b0},
      // escaped ordinary byte
      '{8'h20,     PRED,  NONE, 8'h00, 1'b0},
      '{ESC_BYTE,  PRED,  NONE, 8'h00, 1'b0},
      '{8'hDF,     PRED,  NONE, 8'h00, 1'b0},
      '{FLAG_BYTE, PRED,  NONE, 8'h00, 1'b0}
   };

   // Random phases: frame limit, idle percentages of both sides, line bytes.
   typedef struct packed {
      logic [LEN_W-1:0] limit;
      int               send_idle;
      int               recv_idle;
      int               n_bytes;
   } phase_type;

   localparam int N_PHASES    = 7;
   localparam int PAUSE_PHASE = 3;
   localparam phase_type PHASES [N_PHASES] = '{
      '{17'd3,      25, 61, 260},
      '{17'd0,      25, 61, 150},
      '{17'd1,      61, 25, 200},
      '{17'h1FFFF,  61, 25, 250},
      '{17'd5,       0,  0, 300},
      '{17'd8,       0,  0, 200},
      '{MAX_FRAME_RESET, 0, 0, 200}
   };

   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_LIMIT   = 20000;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   logic             req_full;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   logic [7:0]       rsp_data_byte;
   logic             rsp_last;
   logic             csr_wr_en   = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   // Predictor state, mirrored from the deframer's behavior.
   logic             line_in_frame = 1'b0;
   logic             esc_pending   = 1'b0;
   logic [7:0]       hold_byte     = 8'h00;
   logic             hold_valid    = 1'b0;
   logic [LEN_W-1:0] kept_count    = '0;
   logic [LEN_W-1:0] byte_limit    = MAX_FRAME_RESET;

   rsp_item_type pending_bytes [$];
   int           error_count     = 0;
   int           bytes_sent      = 0;
   int           sender_idle_pct = 0;
   int           recv_idle_pct   = 0;

   hdlc_byte_unstuff_deframer u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_rx_byte   (req_rx_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predictor by one line byte; report the payload byte it releases.
   function automatic void unstuff_byte(input logic [7:0] rx, output bit released,
                                        output rsp_item_type out);
      logic [7:0] b;
      b        = rx;
      released = 1'b0;
      out      = '0;
      if (!line_in_frame) begin
         // hunting: only a flag opens the frame
         if (b == FLAG_BYTE) begin
            line_in_frame = 1'b1;
            kept_count    = '0;
            esc_pending   = 1'b0;
            hold_valid    = 1'b0;
         end
      end else if (b == FLAG_BYTE) begin
         // closing flag: release the held byte with the last mark
         if (hold_valid) begin
            out.data_byte = hold_byte;
            out.last      = 1'b1;
            released      = 1'b1;
         end
         hold_valid  = 1'b0;
         kept_count  = '0;
         esc_pending = 1'b0;
      end else if (b == ESC_BYTE) begin
         esc_pending = 1'b1;
      end else begin
         if (esc_pending) begin
            esc_pending = 1'b0;
            b           = b ^ ESC_XOR;
         end
         // past the limit the byte is dropped, but it still ate the escape
         if (kept_count < byte_limit) begin
            kept_count = kept_count + 1'b1;
            if (hold_valid) begin
               out.data_byte = hold_byte;
               out.last      = 1'b0;
               released      = 1'b1;
            end
            hold_byte  = b;
            hold_valid = 1'b1;
         end
      end
   endfunction

   // Offer one line byte, idling first at random; return once it is taken.
   task automatic send_line_byte(input logic [7:0] b);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // Send a line byte and queue whatever the predictor says it releases.
   task automatic feed_byte(input logic [7:0] b);
      bit           released;
      rsp_item_type out;
      send_line_byte(b);
      unstuff_byte(b, released, out);
      if (released) pending_bytes.push_back(out);
   endtask

   // Mostly well-formed frames with random content; the rest broken sequences.
   task automatic send_random_frame();
      int         kind;
      int         len;
      logic [7:0] b;
      kind = $urandom_range(99);
      if (kind < 80) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(12);
         repeat (len) begin
            case ($urandom_range(7))
               0:       b = FLAG_BYTE;
               1:       b = ESC_BYTE;
               2:       b = FLAG_BYTE ^ ESC_XOR;
               default: b = 8'($urandom_range(255));
            endcase
            // escape the reserved values; now and then escape an ordinary byte
            if (b == FLAG_BYTE || b == ESC_BYTE ||
                ($urandom_range(15) == 0 && (b ^ ESC_XOR) != FLAG_BYTE &&
                 (b ^ ESC_XOR) != ESC_BYTE)) begin
               feed_byte(ESC_BYTE);
               b = b ^ ESC_XOR;
            end
            feed_byte(b);
         end
         feed_byte(FLAG_BYTE);
      end else begin
         // noise: raw escapes, stray flags and escapes right before flags
         len = $urandom_range(6, 1);
         repeat (len) begin
            case ($urandom_range(3))
               0:       feed_byte(ESC_BYTE);
               1:       feed_byte(FLAG_BYTE);
               default: feed_byte(8'($urandom_range(255)));
            endcase
         end
      end
   endtask

   // Hold the sender off until every expected result is in, then let it settle.
   task automatic wait_drained(input int settle);
      int waited;
      waited   = 0;
      req_push <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT);
      if (pending_bytes.size() != 0) begin
         $error("%0d expected results never arrived", pending_bytes.size());
         error_count++;
         pending_bytes.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   // Write the frame limit while the block is idle.
   task automatic write_limit(input logic [LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      byte_limit  = value;
   endtask

   // Compare each taken result with the oldest expectation.
   task automatic take_result();
      rsp_item_type want;
      if (pending_bytes.size() == 0) begin
         $error("unexpected result: data_byte %02h last %0b", rsp_data_byte, rsp_last);
         error_count++;
      end else begin
         want = pending_bytes.pop_front();
         if (rsp_data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, rsp_data_byte);
            error_count++;
         end
         if (rsp_last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, rsp_last);
            error_count++;
         end
      end
   endtask

   // Receiver: check the transaction taken at this edge, then pick the next pop.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) take_result();
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      bit           released;
      rsp_item_type out;
      int           phase_start;
      bit           paused;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset limit, no idling.
      for (int r = 0; r < N_ROWS; r++) begin
         send_line_byte(LINE_ROWS[r].rx_byte);
         unstuff_byte(LINE_ROWS[r].rx_byte, released, out);
         if (LINE_ROWS[r].typed) begin
            // use the typed-in result; the predictor only keeps its state
            if (LINE_ROWS[r].has_result) begin
               out.data_byte = LINE_ROWS[r].data_byte;
               out.last      = LINE_ROWS[r].last;
               pending_bytes.push_back(out);
            end
         end else if (released) begin
            pending_bytes.push_back(out);
         end
      end

      // Random phases: change the limit and the idle pattern only when drained.
      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained(SETTLE_CYCLES);
         sender_idle_pct = PHASES[p].send_idle;
         recv_idle_pct   = PHASES[p].recv_idle;
         write_limit(PHASES[p].limit);
         phase_start = bytes_sent;
         paused      = 1'b0;
         while (bytes_sent - phase_start < PHASES[p].n_bytes) begin
            // halfway through one phase, hold the sender until all results are in
            if (p == PAUSE_PHASE && !paused &&
                bytes_sent - phase_start >= PHASES[p].n_bytes / 2) begin
               wait_drained(0);
               paused = 1'b1;
            end
            send_random_frame();
         end
      end

      wait_drained(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
